/* src/oads_pkg.sv */
// Shared types, codes and constants of the obstacle avoidance drive sequencer.
`default_nettype none

package oads_pkg;

	// Register indexes of the configuration port.
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_OBSTACLE_DISTANCE  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_VALID_DISTANCE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MOVE_DUTY          = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TURN_DUTY          = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_REVERSE_TIME_MS    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TURN_TIME_MS       = 3'd5;
	localparam int unsigned CfgDataW = 16;

	// Reset values of the registers.
	localparam logic [8:0]  RST_OBSTACLE_DISTANCE  = 9'd40;
	localparam logic [8:0]  RST_MIN_VALID_DISTANCE = 9'd2;
	localparam logic [7:0]  RST_MOVE_DUTY          = 8'd255;
	localparam logic [7:0]  RST_TURN_DUTY          = 8'd230;
	localparam logic [15:0] RST_REVERSE_TIME_MS    = 16'd250;
	localparam logic [15:0] RST_TURN_TIME_MS       = 16'd400;

	// H-bridge pin patterns, bit0..bit3 = IN1..IN4.
	localparam logic [3:0] PINS_STOP  = 4'd0;
	localparam logic [3:0] PINS_FWD   = 4'd9;
	localparam logic [3:0] PINS_BACK  = 4'd6;
	localparam logic [3:0] PINS_LEFT  = 4'd10;
	localparam logic [3:0] PINS_RIGHT = 4'd5;

	typedef enum logic [2:0] {
		DRV_STOP  = 3'd0,
		DRV_FWD   = 3'd1,
		DRV_BACK  = 3'd2,
		DRV_LEFT  = 3'd3,
		DRV_RIGHT = 3'd4
	} drive_t;

	typedef enum logic [1:0] {
		MODE_FWD    = 2'd0,
		MODE_START  = 2'd1,
		MODE_TLEFT  = 2'd2,
		MODE_TRIGHT = 2'd3
	} mode_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [8:0]  front_left_cm;
		logic [8:0]  front_center_cm;
		logic [8:0]  front_right_cm;
		logic [8:0]  side_left_cm;
		logic [8:0]  side_right_cm;
	} oads_in_t;

	typedef struct packed {
		logic [3:0] bridge_pins;
		logic [7:0] left_duty;
		logic [7:0] right_duty;
		logic [1:0] mode;
	} oads_out_t;

	typedef struct packed {
		logic [8:0]  obstacle_distance;
		logic [8:0]  min_valid_distance;
		logic [7:0]  move_duty;
		logic [7:0]  turn_duty;
		logic [15:0] reverse_time_ms;
		logic [15:0] turn_time_ms;
	} oads_cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] start_ms;
		drive_t      last_drive;
	} oads_state_t;

endpackage

`default_nettype wire

/* src/oads_in_if.sv */
// Sensor item channel: valid, ready and one tick of sensor readings.
`default_nettype none

interface oads_in_if
	import oads_pkg::*;
();
	logic     valid;
	logic     ready;
	oads_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/oads_out_if.sv */
// Drive result channel: valid, ready and one drive command item.
`default_nettype none

interface oads_out_if
	import oads_pkg::*;
();
	logic      valid;
	logic      ready;
	oads_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/oads_cfg_if.sv */
// Configuration write channel: valid, ready, register index and write data.
`default_nettype none

interface oads_cfg_if
	import oads_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/oads_step.sv */
// Per-tick decision logic: next sequencer state and the drive item for one tick.
`default_nettype none

module oads_step
	import oads_pkg::*;
(
	input  oads_cfg_t   cfg_regs,
	input  oads_state_t state,
	input  oads_in_t    sample,
	output oads_state_t state_next,
	output oads_out_t   result
);

	logic        near_fl;
	logic        near_fc;
	logic        near_fr;
	logic [31:0] elapsed;
	logic [16:0] pivot_limit;
	drive_t      drive;
	mode_t       mode_next;
	logic [31:0] start_next;
	logic [3:0]  pins;
	logic [7:0]  duty;

	function automatic logic is_near(input logic [8:0] d, input oads_cfg_t c);
		return (d < c.obstacle_distance) && (d >= c.min_valid_distance);
	endfunction

	assign near_fl = is_near(sample.front_left_cm, cfg_regs);
	assign near_fc = is_near(sample.front_center_cm, cfg_regs);
	assign near_fr = is_near(sample.front_right_cm, cfg_regs);

	// Elapsed time wraps with the timestamp; the pivot limit cannot wrap.
	assign elapsed     = sample.now_ms - state.start_ms;
	assign pivot_limit = {1'b0, cfg_regs.reverse_time_ms} + {1'b0, cfg_regs.turn_time_ms};

	always_comb begin
		drive      = state.last_drive;
		mode_next  = state.mode;
		start_next = state.start_ms;
		unique case (state.mode)
			MODE_FWD: begin
				drive = DRV_FWD;
				if (near_fl || near_fc || near_fr) begin
					mode_next = MODE_START;
				end
			end
			MODE_START: begin
				start_next = sample.now_ms;
				mode_next  = (sample.side_left_cm > sample.side_right_cm) ?
					MODE_TLEFT : MODE_TRIGHT;
				drive      = DRV_BACK;
			end
			MODE_TLEFT, MODE_TRIGHT: begin
				priority if (elapsed <= {16'd0, cfg_regs.reverse_time_ms}) begin
					drive = DRV_BACK;
				end else if (elapsed <= {15'd0, pivot_limit}) begin
					drive = (state.mode == MODE_TLEFT) ? DRV_LEFT : DRV_RIGHT;
				end else begin
					// Maneuver over: the last drive is repeated once more.
					mode_next = MODE_FWD;
				end
			end
		endcase
	end

	always_comb begin
		unique case (drive)
			DRV_FWD: begin
				pins = PINS_FWD;
				duty = cfg_regs.move_duty;
			end
			DRV_BACK: begin
				pins = PINS_BACK;
				duty = cfg_regs.move_duty;
			end
			DRV_LEFT: begin
				pins = PINS_LEFT;
				duty = cfg_regs.turn_duty;
			end
			DRV_RIGHT: begin
				pins = PINS_RIGHT;
				duty = cfg_regs.turn_duty;
			end
			default: begin
				pins = PINS_STOP;
				duty = 8'd0;
			end
		endcase
	end

	assign state_next.mode       = mode_next;
	assign state_next.start_ms   = start_next;
	assign state_next.last_drive = drive;

	assign result.bridge_pins = pins;
	assign result.left_duty   = duty;
	assign result.right_duty  = duty;
	assign result.mode        = mode_next;

endmodule

`default_nettype wire

/* src/obstacle_avoid_drive_sequencer_top.sv */
// Top level of the obstacle avoidance drive sequencer with its result buffer.
`default_nettype none

// The sequencer takes one sensor item per control tick and gives exactly one
// drive item for it: the four H-bridge direction pins, the two motor duties
// and the mode after the tick. An item is decided in the cycle it is accepted,
// from the item and the sequencer state, and its result is registered in the
// output register, or in the skid register while that is held. The block
// sustains one item per clock while the drive side takes results. The state
// update (mode, maneuver start time, last drive) happens in that same cycle,
// which lets the next item follow at once. Results go to a two-entry output
// buffer, an output register plus a skid register, so the sensor side keeps
// being accepted for one more item while a result waits; sensor ready drops
// only when both entries are full. The configuration port is always ready;
// indexes past the last register are ignored and wider data is truncated.
// Registers are meant to be written only while no items are in flight.

module obstacle_avoid_drive_sequencer_top
	import oads_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	oads_in_if.sink     sensor,
	oads_out_if.source  drive,
	oads_cfg_if.sink    cfg
);

	oads_cfg_t   cfg_q;
	oads_state_t state_q;
	oads_state_t state_next;
	oads_out_t   result;
	oads_out_t   out_data_q;
	oads_out_t   skid_data_q;
	logic        out_valid_q;
	logic        skid_valid_q;
	logic        in_fire;
	logic        out_fire;

	// Configuration writes land directly in the register file.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_distance  <= RST_OBSTACLE_DISTANCE;
			cfg_q.min_valid_distance <= RST_MIN_VALID_DISTANCE;
			cfg_q.move_duty          <= RST_MOVE_DUTY;
			cfg_q.turn_duty          <= RST_TURN_DUTY;
			cfg_q.reverse_time_ms    <= RST_REVERSE_TIME_MS;
			cfg_q.turn_time_ms       <= RST_TURN_TIME_MS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_OBSTACLE_DISTANCE:  cfg_q.obstacle_distance  <= cfg.data[8:0];
				REG_MIN_VALID_DISTANCE: cfg_q.min_valid_distance <= cfg.data[8:0];
				REG_MOVE_DUTY:          cfg_q.move_duty          <= cfg.data[7:0];
				REG_TURN_DUTY:          cfg_q.turn_duty          <= cfg.data[7:0];
				REG_REVERSE_TIME_MS:    cfg_q.reverse_time_ms    <= cfg.data;
				REG_TURN_TIME_MS:       cfg_q.turn_time_ms       <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// The skid register is the last free slot; the sensor side stalls only
	// when it is occupied.
	assign sensor.ready = !skid_valid_q;
	assign in_fire      = sensor.valid && sensor.ready;
	assign out_fire     = out_valid_q && drive.ready;

	oads_step u_step (
		.cfg_regs   (cfg_q),
		.state      (state_q),
		.sample     (sensor.data),
		.state_next (state_next),
		.result     (result)
	);

	// Sequencer state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= MODE_FWD;
			state_q.start_ms   <= 32'd0;
			state_q.last_drive <= DRV_STOP;
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

	// Output buffer control. A new result goes to the output register when it
	// is empty or being emptied; otherwise it parks in the skid register. A
	// parked result moves forward as soon as the output register frees up.
	// An accept cannot coincide with a parked result since ready is then low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q && (!out_valid_q || out_fire)) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				if (!out_valid_q || out_fire) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && (!out_valid_q || out_fire)) begin
			out_data_q <= skid_data_q;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_data_q <= result;
			end else begin
				skid_data_q <= result;
			end
		end
	end

	assign drive.valid = out_valid_q;
	assign drive.data  = out_data_q;

	// A parked result always has an older one ahead of it.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	// The start tick always commits to one of the two turn modes.
	a_start_picks_side: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && state_q.mode == MODE_START) |=>
		(state_q.mode == MODE_TLEFT || state_q.mode == MODE_TRIGHT))
		else $error("start tick did not enter a turn mode");

	// Forward mode can only stay forward or begin a maneuver.
	a_fwd_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && state_q.mode == MODE_FWD) |=>
		(state_q.mode == MODE_FWD || state_q.mode == MODE_START))
		else $error("forward mode left to an unexpected mode");

	// Stop is only the reset drive, so it can be seen in forward mode alone.
	a_stop_only_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.last_drive == DRV_STOP) |-> (state_q.mode == MODE_FWD))
		else $error("stop drive recorded outside forward mode");

endmodule

`default_nettype wire
